[hw/rtl/vlan_mac_learning_table_macros.svh]
// Assertion macros for the VLAN MAC learning table checker
`ifndef VLAN_MAC_LEARNING_TABLE_MACROS_SVH
`define VLAN_MAC_LEARNING_TABLE_MACROS_SVH

// Same-cycle implication
`define VMLT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vmlt assertion failed");

// Next-cycle implication
`define VMLT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vmlt assertion failed");

`endif

[hw/rtl/vmlt_pkg.sv]
// Shared types, constants and control structs of the VLAN MAC learning table
package vmlt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int PORT_COUNT_DEF  = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam int MAC_W   = 48;
    localparam int VLAN_W  = 12;
    localparam int PORT_W  = 4;
    localparam int NOW_W   = 32;
    localparam int AGING_W = 32;

    localparam logic [AGING_W-1:0] AGING_RESET = 32'd300;
    localparam logic [MAC_W-1:0]   MAC_BCAST   = {MAC_W{1'b1}};

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_LEARN  = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;
    localparam logic [1:0] ACT_COPY   = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [MAC_W-1:0]  mac;
        logic [VLAN_W-1:0] vlan_id;
        logic [PORT_W-1:0] port;
        logic [PORT_W-1:0] dest_port;
        logic [NOW_W-1:0]  now;
    } req_t;

    typedef struct packed {
        logic [PORT_W-1:0] out_port;
        logic              hit;
        logic              refreshed;
        logic              table_full;
        logic              last;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic step;
        logic f_step;
        logic eval;
        logic hit;
        logic ins;
        logic cp_wr;
        logic full_set;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       match;
        logic       skip;
        logic       last;
        logic       f_last;
        logic       f_free;
        logic       pend_v;
        logic       out_free;
        logic       found;
        logic       free_v;
    } sts_t;

endpackage

[hw/rtl/vmlt_req_if.sv]
// Request channel interface
interface vmlt_req_if
    import vmlt_pkg::*;
    ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/vmlt_rsp_if.sv]
// Result channel interface
interface vmlt_rsp_if
    import vmlt_pkg::*;
    ();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/vmlt_ctrl.sv]
// Controller state machine sequencing the slot scan of each request
module vmlt_ctrl
    import vmlt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EV   = 3'd2;
    localparam logic [2:0] ST_FIND = 3'd3;
    localparam logic [2:0] ST_INS  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] adv_state;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (sts.last)
        begin
            adv_state = (sts.act == ACT_LEARN) ? ST_INS : ST_FIN;
        end
        else
        begin
            adv_state = ST_RD;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (sts.skip)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EV;
                end
            end
            ST_EV:
            begin
                if (sts.act == ACT_COPY && sts.match)
                begin
                    state_next = ST_FIND;
                end
                else if (!(sts.act == ACT_LOOKUP && sts.match && sts.pend_v && !sts.out_free))
                begin
                    cmd.eval   = 1'b1;
                    cmd.hit    = (sts.act == ACT_LOOKUP) && sts.match;
                    cmd.step   = !sts.last;
                    state_next = adv_state;
                end
            end
            ST_FIND:
            begin
                if (sts.f_free)
                begin
                    cmd.cp_wr  = 1'b1;
                    cmd.step   = !sts.last;
                    state_next = adv_state;
                end
                else if (sts.f_last)
                begin
                    cmd.full_set = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.f_step = 1'b1;
                end
            end
            ST_INS:
            begin
                if (!sts.found)
                begin
                    cmd.ins      = sts.free_v;
                    cmd.full_set = !sts.free_v;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/vmlt_datapath.sv]
// Datapath: entry memories, valid bits, scan pointers and result register
module vmlt_datapath
    import vmlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PORT_COUNT  = PORT_COUNT_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  req_t               req_data,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_we,
    input  logic [AGING_W-1:0] cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output rsp_t               out_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W = (TIME_BITS > AGING_W) ? TIME_BITS : AGING_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [MAC_W-1:0]     mac_mem   [TABLE_DEPTH];
    logic [VLAN_W-1:0]    vlan_mem  [TABLE_DEPTH];
    logic [PORT_W-1:0]    port_mem  [TABLE_DEPTH];
    logic [TIME_BITS-1:0] stamp_mem [TABLE_DEPTH];

    req_t                 q_reg;
    logic [AGING_W-1:0]   aging_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]     r_reg;
    logic [IDX_W-1:0]     f_reg;
    logic [IDX_W-1:0]     free_reg;
    logic                 free_v_reg;
    logic                 found_reg;
    logic                 full_reg;
    logic                 pend_v_reg;
    logic [PORT_W-1:0]    pend_port_reg;
    logic [MAC_W-1:0]     rd_mac_reg;
    logic [VLAN_W-1:0]    rd_vlan_reg;
    logic [PORT_W-1:0]    rd_port_reg;
    logic [TIME_BITS-1:0] rd_stamp_reg;
    logic                 out_valid_reg;
    rsp_t                 out_reg;

    logic [TIME_BITS-1:0] now_tb;
    logic [TIME_BITS-1:0] age;
    logic                 aged;
    logic                 v_r;
    logic                 key_match;
    logic                 port_match;
    logic                 learn_match;
    logic                 lookup_match;
    logic                 bad_port;
    logic                 out_free;
    logic                 we_all;
    logic                 we_stamp;
    logic [IDX_W-1:0]     waddr;
    logic [MAC_W-1:0]     wmac;
    logic [VLAN_W-1:0]    wvlan;
    logic [PORT_W-1:0]    wport;
    logic [TIME_BITS-1:0] wstamp;

    assign now_tb       = TIME_BITS'(q_reg.now);
    assign age          = now_tb - rd_stamp_reg;
    assign aged         = CMP_W'(age) > CMP_W'(aging_reg);
    assign v_r          = valid_reg[r_reg];
    assign key_match    = (rd_vlan_reg == q_reg.vlan_id) && (rd_mac_reg == q_reg.mac);
    assign port_match   = v_r && (rd_port_reg == q_reg.port);
    assign learn_match  = port_match && key_match;
    assign lookup_match = v_r && !aged && key_match;
    assign bad_port     = (9'(q_reg.port) >= 9'(PORT_COUNT)) ||
                          ((q_reg.action == ACT_COPY) && (9'(q_reg.dest_port) >= 9'(PORT_COUNT)));
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        sts          = '0;
        sts.act      = q_reg.action;
        sts.last     = (r_reg == LAST_IDX);
        sts.f_last   = (f_reg == LAST_IDX);
        sts.f_free   = !valid_reg[f_reg];
        sts.pend_v   = pend_v_reg;
        sts.out_free = out_free;
        sts.found    = found_reg;
        sts.free_v   = free_v_reg;
        sts.skip     = bad_port;
        case (q_reg.action)
            ACT_LOOKUP:
            begin
                sts.match = lookup_match;
            end
            ACT_LEARN:
            begin
                sts.match = learn_match;
                if (q_reg.mac == MAC_BCAST)
                begin
                    sts.skip = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                sts.match = port_match;
            end
            ACT_COPY:
            begin
                sts.match = port_match;
                if (q_reg.port == q_reg.dest_port)
                begin
                    sts.skip = 1'b1;
                end
            end
            default:
            begin
                sts.match = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        we_all   = 1'b0;
        we_stamp = 1'b0;
        waddr    = r_reg;
        wmac     = q_reg.mac;
        wvlan    = q_reg.vlan_id;
        wport    = q_reg.port;
        wstamp   = now_tb;
        if (cmd.ins)
        begin
            we_all = 1'b1;
            waddr  = free_reg;
        end
        else if (cmd.cp_wr)
        begin
            we_all = 1'b1;
            waddr  = f_reg;
            wmac   = rd_mac_reg;
            wvlan  = rd_vlan_reg;
            wport  = q_reg.dest_port;
            wstamp = rd_stamp_reg;
        end
        else if (cmd.eval && q_reg.action == ACT_LEARN && learn_match)
        begin
            we_stamp = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_all)
        begin
            mac_mem[waddr]  <= wmac;
            vlan_mem[waddr] <= wvlan;
            port_mem[waddr] <= wport;
        end
        if (we_all || we_stamp)
        begin
            stamp_mem[waddr] <= wstamp;
        end
        if (cmd.rd)
        begin
            rd_mac_reg   <= mac_mem[r_reg];
            rd_vlan_reg  <= vlan_mem[r_reg];
            rd_port_reg  <= port_mem[r_reg];
            rd_stamp_reg <= stamp_mem[r_reg];
        end
        if (cmd.load)
        begin
            q_reg <= req_data;
        end
        if (cmd.hit)
        begin
            pend_port_reg <= rd_port_reg;
        end
        if (cmd.eval && q_reg.action == ACT_LEARN && !v_r && !free_v_reg)
        begin
            free_reg <= r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_reg  <= AGING_RESET;
            valid_reg  <= '0;
            r_reg      <= '0;
            f_reg      <= '0;
            free_v_reg <= 1'b0;
            found_reg  <= 1'b0;
            full_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                aging_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                r_reg      <= '0;
                f_reg      <= '0;
                free_v_reg <= 1'b0;
                found_reg  <= 1'b0;
                full_reg   <= 1'b0;
                pend_v_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                r_reg <= r_reg + 1'b1;
            end
            if (cmd.f_step)
            begin
                f_reg <= f_reg + 1'b1;
            end
            if (cmd.eval)
            begin
                case (q_reg.action)
                    ACT_LOOKUP:
                    begin
                        if (v_r && aged)
                        begin
                            valid_reg[r_reg] <= 1'b0;
                        end
                    end
                    ACT_LEARN:
                    begin
                        if (learn_match)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (!v_r)
                        begin
                            free_v_reg <= 1'b1;
                        end
                    end
                    ACT_FLUSH:
                    begin
                        if (port_match)
                        begin
                            valid_reg[r_reg] <= 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.hit)
            begin
                pend_v_reg <= 1'b1;
            end
            if (cmd.ins)
            begin
                valid_reg[free_reg] <= 1'b1;
            end
            if (cmd.cp_wr)
            begin
                valid_reg[f_reg] <= 1'b1;
            end
            if (cmd.full_set)
            begin
                full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.hit && pend_v_reg) || cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hit && pend_v_reg)
        begin
            out_reg <= '{out_port: pend_port_reg, hit: 1'b1, refreshed: 1'b0,
                         table_full: 1'b0, last: 1'b0};
        end
        else if (cmd.fin)
        begin
            if (q_reg.action == ACT_LOOKUP)
            begin
                out_reg <= '{out_port: pend_v_reg ? pend_port_reg : '0, hit: pend_v_reg,
                             refreshed: 1'b0, table_full: 1'b0, last: 1'b1};
            end
            else
            begin
                out_reg <= '{out_port: '0, hit: 1'b0, refreshed: found_reg,
                             table_full: full_reg, last: 1'b1};
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[hw/rtl/vlan_mac_learning_table.sv]
// Top level of the VLAN MAC learning table
// Usage:
// - req channel: one request (action, mac, vlan_id, port, dest_port, now) at a
//   time; req.ready is high only while no request is in flight.
// - rsp channel: lookup gives one result per matching slot in slot order, or
//   one miss result; learn, flush and copy give one result. last marks the end.
// - cfg_we/cfg_wdata write aging_time; write only between requests.
// Scan: a request scans all TABLE_DEPTH slots through single-port entry
//   memories, reading then evaluating each slot; a learn adds an insert
//   step; a copy probes for a free slot and writes one per match, and ends
//   the scan early when none is left. Out-of-range ports, broadcast learn
//   and copy onto the same port skip the scan and go straight to the result.
// Reset: valid bits clear at once, aging_time returns to 300; no clearing pass.
// Stall: results sit in an output register; a lookup scan waits at a second
//   hit while the previous result is not taken, and the final result waits
//   for the output register to be free; the next request is then accepted.
module vlan_mac_learning_table
    import vmlt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PORT_COUNT  = PORT_COUNT_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    vmlt_req_if.sink           req,
    vmlt_rsp_if.source         rsp,
    input  logic               cfg_we,
    input  logic [AGING_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    vmlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vmlt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_COUNT  (PORT_COUNT),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req.payload),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.payload)
    );

endmodule

[hw/rtl/vmlt_checker.sv]
// Port-level checker for the VLAN MAC learning table and its bind
`include "vlan_mac_learning_table_macros.svh"

module vmlt_checker
    import vmlt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_payload
);

    `VMLT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `VMLT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
    `VMLT_ASSERT_NOW(a_hit_excl, rsp_valid && rsp_payload.hit, !rsp_payload.refreshed && !rsp_payload.table_full)

endmodule

bind vlan_mac_learning_table vmlt_checker u_vmlt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
